@@ sv/sfd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared constants and types of the stereo feedback delay: register map and
// the fixed widths of the configuration registers.
// ----------------------------------------------------------------------------
package sfd_pkg;

  // configuration register widths
  localparam int DLY_W     = 17;
  localparam int FB_W      = 16;
  localparam int MIX_W     = 17;
  localparam int CFG_W     = 17;
  localparam int CFG_IDX_W = 2;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DELAY    = 2'd0,
    CFG_FEEDBACK = 2'd1,
    CFG_MIX      = 2'd2
  } cfg_idx_e;

endpackage : sfd_pkg
`default_nettype wire

@@ sv/stereo_feedback_delay_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// A word taken on s_axis passes stages 1 to 4 and the output register to m_axis.
// Throughput: one word per cycle while no stall or delay reduction holds it; when
// the delay mod DEPTH is 1, the tap read waits for the previous word's write to pass
// the port. A delay write starts a modulo-DEPTH reduction; no word is taken while it runs.
// Reset clears control state only; a fill mark (write position plus wrap flag)
// makes unwritten line entries read as zero, so there is no clearing pass.
// ----------------------------------------------------------------------------
// stereo_feedback_delay_core
// Stereo feedback delay line with dry/wet mix, one frame of two 24-bit samples per word,
// delay lines held in two simple dual-port synchronous memories.
// ----------------------------------------------------------------------------
module stereo_feedback_delay_core
  import sfd_pkg::*;
#(
  parameter int DEPTH       = 131072,
  parameter int SAMPLE_BITS = 24,
  parameter int GAIN_BITS   = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // configuration write port
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_addr_i,
  input  wire logic [CFG_W-1:0]     cfg_wdata_i,
  // input stream
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  // tdata: left_in, right_in, zero pad
  input  wire logic [((2*SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
  // output stream
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // tdata: left_out, right_out, zero pad
  output logic [((2*SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata
);

  localparam int SW      = SAMPLE_BITS;
  localparam int GW      = GAIN_BITS;
  localparam int TDATA_W = ((2*SW+7)/8)*8;
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int MXW     = (GW + 1 > MIX_W) ? GW + 1 : MIX_W;
  localparam int FBP_W   = SW + FB_W + 1;
  localparam int GP_W    = SW + GW + 2;
  localparam int WIDE    = ((FBP_W > GP_W) ? FBP_W : GP_W) + 1;

  // reciprocal of DEPTH, exact quotient for every delay value
  localparam int             RSH     = DLY_W + AW;
  localparam int             RMW     = DLY_W + 2;
  localparam longint         RCP_L   = ((longint'(1) << RSH) + longint'(DEPTH) - 1) /
                                       longint'(DEPTH);
  localparam logic [RMW-1:0] RCP     = RMW'(RCP_L);
  localparam logic [AW:0]    DEPTH_C = (AW+1)'(DEPTH);

  localparam logic signed [WIDE-1:0] RND_W  = WIDE'(1) << (GW - 1);
  localparam logic signed [WIDE-1:0] SMAX_W = {{(WIDE-SW+1){1'b0}}, {(SW-1){1'b1}}};
  localparam logic signed [WIDE-1:0] SMIN_W = {{(WIDE-SW+1){1'b1}}, {(SW-1){1'b0}}};
  localparam logic signed [SW:0]     SMAX_A = {2'b00, {(SW-1){1'b1}}};
  localparam logic signed [SW:0]     SMIN_A = {2'b11, {(SW-1){1'b0}}};
  localparam logic [MXW-1:0]         ONE_X  = MXW'(1) << GW;
  localparam logic [AW-1:0]          WP_LAST = AW'(DEPTH - 1);

  // round half up by 2^GW, then saturate to the sample range
  function automatic logic signed [SW-1:0] round_sat(input logic signed [WIDE-1:0] p);
    logic signed [WIDE-1:0] t;
    t = (p + RND_W) >>> GW;
    if (t > SMAX_W) begin
      t = SMAX_W;
    end else if (t < SMIN_W) begin
      t = SMIN_W;
    end
    return SW'(t);
  endfunction

  // saturating add of two samples
  function automatic logic signed [SW-1:0] sat_add(input logic signed [SW-1:0] a,
                                                   input logic signed [SW-1:0] b);
    logic signed [SW:0] s;
    s = (SW+1)'(a) + (SW+1)'(b);
    if (s > SMAX_A) begin
      s = SMAX_A;
    end else if (s < SMIN_A) begin
      s = SMIN_A;
    end
    return SW'(s);
  endfunction

  // configuration registers
  logic [FB_W-1:0]  fb_q;
  logic [MIX_W-1:0] mix_q;
  logic [GW:0]      mix_eff_q;
  logic [GW:0]      dry_gain_q;
  logic [MXW-1:0]   mix_x;

  // delay reduction
  logic [DLY_W-1:0]     red_q;
  logic                 red_busy_q;
  logic                 red_ph_q;
  logic [DLY_W-1:0]     red_quo_q;
  logic [DLY_W+RMW-1:0] red_prod;
  logic [DLY_W+AW:0]    red_back;

  // write position and fill mark
  logic [AW-1:0] wp_q;
  logic          wrapped_q;
  logic [AW-1:0] dmod;
  logic [AW-1:0] rd_addr;
  logic          rd_written;

  // handshake and pipeline control
  logic in_acc;
  logic hazard;
  logic out_load;
  logic adv;
  logic wr_en;

  // stage 1: memory read data
  logic                 p1_valid_q;
  logic [AW-1:0]        p1_wp_q;
  logic                 p1_written_q;
  logic                 p1_zero_q;
  logic signed [SW-1:0] p1_in_l_q, p1_in_r_q;
  logic signed [SW-1:0] rdata_l_q, rdata_r_q;
  logic                 fwd_hit_q;
  logic signed [SW-1:0] fwd_l_q, fwd_r_q;
  logic signed [SW-1:0] old_l, old_r;

  // stage 2: feedback and dry products
  logic                    p2_valid_q;
  logic [AW-1:0]           p2_wp_q;
  logic                    p2_zero_q;
  logic signed [SW-1:0]    p2_in_l_q, p2_in_r_q;
  logic signed [SW-1:0]    p2_old_l_q, p2_old_r_q;
  logic signed [FBP_W-1:0] p2_fbp_l_q, p2_fbp_r_q;
  logic signed [GP_W-1:0]  p2_dryp_l_q, p2_dryp_r_q;
  logic signed [SW-1:0]    stored_l, stored_r;

  // stage 3: tap and dry term
  logic                 p3_valid_q;
  logic signed [SW-1:0] p3_tap_l_q, p3_tap_r_q;
  logic signed [SW-1:0] p3_dry_l_q, p3_dry_r_q;

  // stage 4: wet product
  logic                   p4_valid_q;
  logic signed [SW-1:0]   p4_dry_l_q, p4_dry_r_q;
  logic signed [GP_W-1:0] p4_wetp_l_q, p4_wetp_r_q;

  // output register
  logic                 out_valid_q;
  logic signed [SW-1:0] out_l_q, out_r_q;

  // delay lines
  logic [SW-1:0] mem_l [0:DEPTH-1];
  logic [SW-1:0] mem_r [0:DEPTH-1];

  // configuration writes, the delay goes through the reduction below
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fb_q    <= '0;
      mix_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_FEEDBACK: fb_q    <= cfg_wdata_i[FB_W-1:0];
        CFG_MIX:      mix_q   <= cfg_wdata_i[MIX_W-1:0];
        default:      ;
      endcase
    end
  end

  // wet gain clipped to one, dry gain its complement
  assign mix_x = MXW'(mix_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mix_eff_q  <= '0;
      dry_gain_q <= ONE_X[GW:0];
    end else if (mix_x > ONE_X) begin
      mix_eff_q  <= ONE_X[GW:0];
      dry_gain_q <= '0;
    end else begin
      mix_eff_q  <= mix_x[GW:0];
      dry_gain_q <= ONE_X[GW:0] - mix_x[GW:0];
    end
  end

  // delay mod DEPTH: quotient by reciprocal, then subtract quotient times DEPTH
  assign red_prod = (DLY_W+RMW)'(red_q) * (DLY_W+RMW)'(RCP);
  assign red_back = (DLY_W+AW+1)'(red_quo_q) * (DLY_W+AW+1)'(DEPTH_C);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_q      <= '0;
      red_quo_q  <= '0;
      red_busy_q <= 1'b0;
      red_ph_q   <= 1'b0;
    end else if (cfg_we_i && cfg_addr_i == CFG_DELAY) begin
      red_q      <= cfg_wdata_i[DLY_W-1:0];
      red_busy_q <= 1'b1;
      red_ph_q   <= 1'b0;
    end else if (red_busy_q) begin
      if (!red_ph_q) begin
        red_quo_q <= DLY_W'(red_prod >> RSH);
        red_ph_q  <= 1'b1;
      end else begin
        red_q      <= red_q - red_back[DLY_W-1:0];
        red_busy_q <= 1'b0;
      end
    end
  end

  // read address and whether that entry was ever written
  assign dmod = AW'(red_q);

  always_comb begin
    if (wp_q >= dmod) begin
      rd_addr = wp_q - dmod;
    end else begin
      rd_addr = AW'((AW+1)'(wp_q) + (AW+1)'(DEPTH) - (AW+1)'(dmod));
    end
    rd_written = wrapped_q || (rd_addr < wp_q);
  end

  // handshake: stall only on a full output with a word behind it; input also waits on hazard or reduction
  assign out_load      = !out_valid_q || m_axis_tready;
  assign adv           = out_load || !p4_valid_q;
  assign hazard        = p1_valid_q && (p1_wp_q == rd_addr);
  assign s_axis_tready = adv && !hazard && !red_busy_q;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign wr_en         = adv && p2_valid_q;

  // write position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q      <= '0;
      wrapped_q <= 1'b0;
    end else if (in_acc) begin
      if (wp_q == WP_LAST) begin
        wp_q      <= '0;
        wrapped_q <= 1'b1;
      end else begin
        wp_q <= wp_q + 1'b1;
      end
    end
  end

  // delay line memories, read and write on the advancing edge
  always_ff @(posedge clk_i) begin
    if (adv) begin
      rdata_l_q <= mem_l[rd_addr];
      rdata_r_q <= mem_r[rd_addr];
      if (wr_en) begin
        mem_l[p2_wp_q] <= stored_l;
        mem_r[p2_wp_q] <= stored_r;
      end
    end
  end

  // pipeline valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q <= 1'b0;
      p2_valid_q <= 1'b0;
      p3_valid_q <= 1'b0;
      p4_valid_q <= 1'b0;
    end else if (adv) begin
      p1_valid_q <= in_acc;
      p2_valid_q <= p1_valid_q;
      p3_valid_q <= p2_valid_q;
      p4_valid_q <= p3_valid_q;
    end
  end

  // stage 1 capture, with forwarding of the word written at the same edge
  always_ff @(posedge clk_i) begin
    if (adv) begin
      p1_wp_q      <= wp_q;
      p1_written_q <= rd_written;
      p1_zero_q    <= (dmod == '0);
      p1_in_l_q    <= s_axis_tdata[SW-1:0];
      p1_in_r_q    <= s_axis_tdata[2*SW-1:SW];
      fwd_hit_q    <= p2_valid_q && (p2_wp_q == rd_addr);
      fwd_l_q      <= stored_l;
      fwd_r_q      <= stored_r;
    end
  end

  // old line content as the model sees it
  always_comb begin
    if (fwd_hit_q) begin
      old_l = fwd_l_q;
      old_r = fwd_r_q;
    end else if (p1_written_q) begin
      old_l = rdata_l_q;
      old_r = rdata_r_q;
    end else begin
      old_l = '0;
      old_r = '0;
    end
  end

  // stage 2: feedback and dry products
  always_ff @(posedge clk_i) begin
    if (adv) begin
      p2_wp_q     <= p1_wp_q;
      p2_zero_q   <= p1_zero_q;
      p2_in_l_q   <= p1_in_l_q;
      p2_in_r_q   <= p1_in_r_q;
      p2_old_l_q  <= old_l;
      p2_old_r_q  <= old_r;
      p2_fbp_l_q  <= FBP_W'(old_l) * FBP_W'($signed({1'b0, fb_q}));
      p2_fbp_r_q  <= FBP_W'(old_r) * FBP_W'($signed({1'b0, fb_q}));
      p2_dryp_l_q <= GP_W'(p1_in_l_q) * GP_W'($signed({1'b0, dry_gain_q}));
      p2_dryp_r_q <= GP_W'(p1_in_r_q) * GP_W'($signed({1'b0, dry_gain_q}));
    end
  end

  // value stored back into the line
  assign stored_l = sat_add(p2_in_l_q, round_sat(WIDE'(p2_fbp_l_q)));
  assign stored_r = sat_add(p2_in_r_q, round_sat(WIDE'(p2_fbp_r_q)));

  // stage 3: tap is the fresh word when the delay is zero
  always_ff @(posedge clk_i) begin
    if (adv) begin
      p3_tap_l_q <= p2_zero_q ? stored_l : p2_old_l_q;
      p3_tap_r_q <= p2_zero_q ? stored_r : p2_old_r_q;
      p3_dry_l_q <= round_sat(WIDE'(p2_dryp_l_q));
      p3_dry_r_q <= round_sat(WIDE'(p2_dryp_r_q));
    end
  end

  // stage 4: wet product
  always_ff @(posedge clk_i) begin
    if (adv) begin
      p4_dry_l_q  <= p3_dry_l_q;
      p4_dry_r_q  <= p3_dry_r_q;
      p4_wetp_l_q <= GP_W'(p3_tap_l_q) * GP_W'($signed({1'b0, mix_eff_q}));
      p4_wetp_r_q <= GP_W'(p3_tap_r_q) * GP_W'($signed({1'b0, mix_eff_q}));
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= p4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_l_q <= sat_add(p4_dry_l_q, round_sat(WIDE'(p4_wetp_l_q)));
      out_r_q <= sat_add(p4_dry_r_q, round_sat(WIDE'(p4_wetp_r_q)));
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = TDATA_W'({out_r_q, out_l_q});

endmodule : stereo_feedback_delay_core
`default_nettype wire

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for stereo_feedback_delay_core. Stereo words are pushed
// with random gaps and back pressure. Each accepted word runs through a
// bench-side copy of both delay lines, and every output word is compared per
// channel against the oldest predicted word.
// ----------------------------------------------------------------------------
module tb_top;
  import sfd_pkg::*;

  localparam int          SMP_W          = 24;
  localparam int          LINE_DEPTH     = 131072;
  localparam int          TDATA_W        = 48;
  localparam longint      Q_ONE          = 64'sd65536;
  localparam longint      SMP_MAX        = 64'sd8388607;
  localparam longint      SMP_MIN        = -64'sd8388608;
  localparam int          IDLE_PCT       = 32;
  localparam int          HOLD_CYCLES    = 300;
  localparam int          WATCHDOG_LIMIT = 4000;
  localparam int          PHASES         = 12;
  localparam int          PHASE_WORDS    = 55;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef logic signed [SMP_W-1:0] sample_t;
  // tdata layout: left in the low bits, right above it
  typedef struct packed {
    sample_t right;
    sample_t left;
  } frame_t;

  bit                   clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_addr_i;
  logic [CFG_W-1:0]     cfg_wdata_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  // tdata: left_in, right_in
  logic [TDATA_W-1:0]   s_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  // tdata: left_out, right_out
  logic [TDATA_W-1:0]   m_axis_tdata;

  // bench copy of the delay lines and registers
  bit signed [SMP_W-1:0] echo_line [2][LINE_DEPTH];
  logic [16:0]           wr_pos;
  logic [DLY_W-1:0]      dly_reg;
  logic [FB_W-1:0]       fb_reg;
  logic [MIX_W-1:0]      mix_reg;
  frame_t                out_frames_due [$];

  int errors;
  bit calm;
  int hold_reqs;
  int hold_seen;
  int hold_left;
  int idle_cycles;

  stereo_feedback_delay_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // clock
  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic longint sat_smp(longint x);
    if (x > SMP_MAX) return SMP_MAX;
    if (x < SMP_MIN) return SMP_MIN;
    return x;
  endfunction

  // exact product, round half up, floor shift, then clip
  function automatic longint gain_q16(longint s, longint g);
    longint p;
    p = s * g + 64'sd32768;
    return sat_smp(p >>> 16);
  endfunction

  // one channel: feed back into the line, then mix dry and tap
  function automatic sample_t delay_mix_channel(int ch, logic [16:0] rd, sample_t in_s);
    longint old_v;
    longint stored;
    longint tap;
    longint wet;
    old_v = echo_line[ch][rd];
    stored = sat_smp(longint'(in_s) + gain_q16(old_v, longint'(fb_reg)));
    echo_line[ch][wr_pos] = stored[SMP_W-1:0];
    // zero delay hears the word just written
    tap = (rd == wr_pos) ? stored : old_v;
    wet = longint'(mix_reg);
    if (wet > Q_ONE) wet = Q_ONE;
    return sample_t'(sat_smp(gain_q16(longint'(in_s), Q_ONE - wet) + gain_q16(tap, wet)));
  endfunction

  task automatic report_mismatch(string what);
    $display("%0t ns mismatch: %s", $time, what);
    errors++;
  endtask

  // one stereo word in, prediction on acceptance
  task automatic send_frame(sample_t l, sample_t r);
    frame_t      res;
    logic [16:0] rd;
    if (!calm) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {r, l};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    // 17-bit wrap is the modulo of the line depth
    rd = wr_pos - dly_reg;
    res.left  = delay_mix_channel(0, rd, l);
    res.right = delay_mix_channel(1, rd, r);
    wr_pos = wr_pos + 17'd1;
    out_frames_due.push_back(res);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (out_frames_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CFG_DELAY:    dly_reg = val[DLY_W-1:0];
      CFG_FEEDBACK: fb_reg  = val[FB_W-1:0];
      CFG_MIX:      mix_reg = val[MIX_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(logic [CFG_W-1:0] d, logic [CFG_W-1:0] fb, logic [CFG_W-1:0] mix);
    cfg_write(CFG_DELAY, d);
    cfg_write(CFG_FEEDBACK, fb);
    cfg_write(CFG_MIX, mix);
  endtask

  function automatic sample_t pick_sample();
    int k;
    k = $urandom_range(99);
    if (k < 4) return sample_t'(SMP_MAX);
    if (k < 8) return sample_t'(SMP_MIN);
    if (k < 11) return '0;
    if (k < 14) return '1;
    if (k < 40) return sample_t'($urandom_range(0, 2000) - 1000);
    return sample_t'($urandom);
  endfunction

  // reset state passes input straight through
  task automatic test_dry_path();
    send_frame(sample_t'(SMP_MAX), sample_t'(SMP_MIN));
    send_frame(sample_t'(SMP_MIN), sample_t'(SMP_MAX));
    send_frame('0, '1);
    send_frame('1, '0);
    send_frame(24'sh555555, 24'shAAAAAA);
    send_frame(24'shAAAAAA, 24'sh555555);
    wait_idle();
  endtask

  // zero delay, fully wet: tap is the word just stored
  task automatic test_zero_delay_wet();
    set_regs(17'd0, 17'd65535, 17'd65536);
    send_frame(sample_t'(SMP_MAX), sample_t'(SMP_MIN));
    send_frame(sample_t'(SMP_MAX), sample_t'(SMP_MIN));
    send_frame(sample_t'(SMP_MIN), sample_t'(SMP_MAX));
    send_frame('1, 24'sh000001);
    send_frame(24'sh555555, 24'shAAAAAA);
    wait_idle();
  endtask

  // wet share above one, then a write to the spare index
  task automatic test_wet_clamp();
    set_regs(17'd5, 17'd65470, 17'h1FFFF);
    send_frame(sample_t'(SMP_MAX), 24'sh123456);
    send_frame(sample_t'(SMP_MIN), -24'sh123456);
    send_frame(24'sh000100, '1);
    wait_idle();
    cfg_write(CFG_SPARE, 17'h1FFFF);
    send_frame(24'sh7FF000, -24'sh7FF000);
    send_frame('0, '0);
    wait_idle();
  endtask

  // longest delay reads unwritten entries, delay of one makes each word wait for the previous write
  task automatic test_line_ends();
    set_regs(17'h1FFFF, 17'd32768, 17'd32768);
    send_frame(sample_t'(SMP_MAX), sample_t'(SMP_MAX));
    send_frame(sample_t'(SMP_MIN), sample_t'(SMP_MIN));
    send_frame(24'sh0F0F0F, -24'sh0F0F0F);
    wait_idle();
    cfg_write(CFG_DELAY, 17'd1);
    repeat (4) send_frame(pick_sample(), pick_sample());
    wait_idle();
  endtask

  // random settings per phase, random words within each
  task automatic test_random_settings();
    logic [CFG_W-1:0] d;
    logic [CFG_W-1:0] fb;
    logic [CFG_W-1:0] mix;
    for (int ph = 0; ph < PHASES; ph++) begin
      case ($urandom_range(9))
        0:       d = 17'd0;
        1:       d = 17'd1;
        2:       d = 17'h1FFFF;
        3, 4, 5: d = CFG_W'($urandom_range(2, 40));
        6, 7, 8: d = CFG_W'($urandom_range(41, 600));
        default: d = CFG_W'($urandom);
      endcase
      case ($urandom_range(5))
        0:       fb = 17'd0;
        1:       fb = 17'd65470;
        2:       fb = 17'd65535;
        default: fb = CFG_W'($urandom_range(0, 65535));
      endcase
      case ($urandom_range(5))
        0:       mix = 17'd0;
        1:       mix = 17'd65536;
        2:       mix = CFG_W'($urandom_range(65537, 131071));
        default: mix = CFG_W'($urandom_range(0, 65536));
      endcase
      set_regs(d, fb, mix);
      repeat (PHASE_WORDS) send_frame(pick_sample(), pick_sample());
      wait_idle();
    end
  endtask

  // stretch with no idling on either side
  task automatic test_long_calm();
    calm <= 1'b1;
    set_regs(17'd3, CFG_W'($urandom_range(0, 65535)), CFG_W'($urandom_range(0, 65536)));
    repeat (60) send_frame(pick_sample(), pick_sample());
    wait_idle();
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    hold_reqs <= hold_reqs + 1;
    repeat (60) send_frame(pick_sample(), pick_sample());
    wait_idle();
    calm <= 1'b0;
  endtask

  // receiver ready, with random idling and a long hold on request
  always @(posedge clk_i) begin
    if (hold_reqs != hold_seen) begin
      hold_seen     <= hold_reqs;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // output check against the oldest prediction
  always @(posedge clk_i) begin : check_out
    frame_t want;
    frame_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (out_frames_due.size() == 0) begin
        report_mismatch($sformatf("unexpected word %h", got));
      end else begin
        want = out_frames_due.pop_front();
        if (got.left !== want.left)
          report_mismatch($sformatf("left_out exp %0d got %0d", want.left, got.left));
        if (got.right !== want.right)
          report_mismatch($sformatf("right_out exp %0d got %0d", want.right, got.right));
      end
    end
  end

  // watchdog on cycles with no word moving
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("stereo_feedback_delay_core verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // test sequence
  initial begin
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_addr_i    <= '0;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    wr_pos  = '0;
    dly_reg = '0;
    fb_reg  = '0;
    mix_reg = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_dry_path();
    test_zero_delay_wet();
    test_wet_clamp();
    test_line_ends();
    test_random_settings();
    test_long_calm();
    test_backpressure();
    wait_idle();
    if (errors == 0) begin
      $display("stereo_feedback_delay_core verification clean");
    end else begin
      $display("stereo_feedback_delay_core verification failed");
    end
    $finish;
  end

endmodule
